// ===== rtl/epvm_pkg.sv =====
// ----------------------------------------------------------------------------
// epvm_pkg
// Widths shared by the eye position pipeline and its quotient unit.
// ----------------------------------------------------------------------------
package epvm_pkg;
    localparam int IN_W   = 32;            // Q16.16 input fields
    localparam int OUT_W  = 48;            // Q32.16 result fields
    localparam int PROD_W = 2 * IN_W;      // element by element product
    localparam int ADJ_W  = PROD_W + 1;    // cofactor
    localparam int PART_W = ADJ_W;         // partial product of 32 x 33 bits
    localparam int MUL_W  = IN_W + ADJ_W;  // element by cofactor product
    localparam int SUM_W  = MUL_W + 2;     // sum of three such products
    localparam int WIDE_W = 128;           // scaled numerator, modulo 2^128
    localparam int DEN_W  = SUM_W + 1;     // doubled determinant magnitude
    localparam int QUO_W  = OUT_W;         // quotient bits developed
    localparam int CMP_W  = DEN_W + QUO_W + 1;
    localparam int NPROD  = 12;            // three det terms, nine numerator terms
endpackage

// ===== rtl/epvm_div.sv =====
// ----------------------------------------------------------------------------
// epvm_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module epvm_div
    import epvm_pkg::*;
#(
    parameter int TAG_W = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [WIDE_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    input  logic [TAG_W-1:0]  tag,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf,
    output logic [TAG_W-1:0]  out_tag
);
    logic [QUO_W:0]     v_reg;
    logic [WIDE_W-1:0]  r_reg [QUO_W+1];
    logic [DEN_W-1:0]   d_reg [QUO_W+1];
    logic [QUO_W-1:0]   q_reg [QUO_W+1];
    logic               o_reg [QUO_W+1];
    logic [TAG_W-1:0]   t_reg [QUO_W+1];
    logic [CMP_W-1:0]   lim0;

    // flag a quotient of 2^QUO_W or more
    assign lim0 = {1'b0, den, {QUO_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        r_reg[0] <= num;
        d_reg[0] <= den;
        q_reg[0] <= '0;
        o_reg[0] <= (CMP_W'(num) >= lim0);
        t_reg[0] <= tag;
    end

    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_stage
        localparam int B = QUO_W - s;
        logic [CMP_W-1:0] sh;
        logic             ge;
        assign sh = CMP_W'(d_reg[s-1]) << B;
        assign ge = CMP_W'(r_reg[s-1]) >= sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            r_reg[s] <= ge ? (r_reg[s-1] - sh[WIDE_W-1:0]) : r_reg[s-1];
            d_reg[s] <= d_reg[s-1];
            q_reg[s] <= q_reg[s-1] | (QUO_W'(ge) << B);
            o_reg[s] <= o_reg[s-1];
            t_reg[s] <= t_reg[s-1];
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign quo       = q_reg[QUO_W];
    assign ovf       = o_reg[QUO_W];
    assign out_tag   = t_reg[QUO_W];
endmodule

// ===== rtl/eye_position_from_view_matrix.sv =====
// ----------------------------------------------------------------------------
// eye_position_from_view_matrix
// Eye position -(t * inv(M)) from a row-major model-view matrix, fixed point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// The 48 quotient stages of the divider set most of the latency.
// Reset clears every valid bit; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
module eye_position_from_view_matrix
    import epvm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  rot_00,
    input  logic signed [IN_W-1:0]  rot_01,
    input  logic signed [IN_W-1:0]  rot_02,
    input  logic signed [IN_W-1:0]  rot_10,
    input  logic signed [IN_W-1:0]  rot_11,
    input  logic signed [IN_W-1:0]  rot_12,
    input  logic signed [IN_W-1:0]  rot_20,
    input  logic signed [IN_W-1:0]  rot_21,
    input  logic signed [IN_W-1:0]  rot_22,
    input  logic signed [IN_W-1:0]  trans_x,
    input  logic signed [IN_W-1:0]  trans_y,
    input  logic signed [IN_W-1:0]  trans_z,
    output logic                    done,
    output logic signed [OUT_W-1:0] eye_x,
    output logic signed [OUT_W-1:0] eye_y,
    output logic signed [OUT_W-1:0] eye_z,
    output logic                    singular
);
    logic signed [IN_W-1:0]   m [9];
    logic signed [IN_W-1:0]   t [3];

    // stage 1: element products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] pa_reg [9];
    logic signed [PROD_W-1:0] pb_reg [9];
    logic signed [IN_W-1:0]   mr1_reg [3];
    logic signed [IN_W-1:0]   tt1_reg [3];
    // stage 2: cofactors
    logic                     v2_reg;
    logic signed [ADJ_W-1:0]  adj_reg [9];
    logic signed [IN_W-1:0]   mr2_reg [3];
    logic signed [IN_W-1:0]   tt2_reg [3];
    // stage 3: partial products
    logic                     v3_reg;
    logic signed [PART_W-1:0] lo_reg [NPROD];
    logic signed [PART_W-1:0] hi_reg [NPROD];
    // stage 4: determinant and numerators
    logic                     v4_reg;
    logic signed [SUM_W-1:0]  det_reg;
    logic signed [SUM_W-1:0]  num_reg [3];
    logic signed [SUM_W-1:0]  prod [NPROD];
    // stage 5: magnitudes for the divider
    logic                     v5_reg;
    logic [WIDE_W-1:0]        np_reg [3];
    logic [DEN_W-1:0]         dp_reg;
    logic                     neg_reg [3];
    logic                     sing5_reg;
    // divider outputs
    logic                     dv [3];
    logic [QUO_W-1:0]         dq [3];
    logic                     dovf [3];
    logic [1:0]               dtag [3];
    logic signed [OUT_W-1:0]  res [3];
    // output registers
    logic                     done_reg;
    logic signed [OUT_W-1:0]  eye_reg [3];
    logic                     sing_reg;

    // full-width signed product of two matrix elements
    function automatic logic signed [PROD_W-1:0] mul_el(input logic signed [IN_W-1:0] x,
                                                        input logic signed [IN_W-1:0] y);
        mul_el = PROD_W'(x) * PROD_W'(y);
    endfunction

    assign busy = 1'b0;

    assign m[0] = rot_00;  assign m[1] = rot_01;  assign m[2] = rot_02;
    assign m[3] = rot_10;  assign m[4] = rot_11;  assign m[5] = rot_12;
    assign m[6] = rot_20;  assign m[7] = rot_21;  assign m[8] = rot_22;
    assign t[0] = trans_x; assign t[1] = trans_y; assign t[2] = trans_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= dv[0];
        end
    end

    // Stage 1: the two products of each adjugate entry, row-major adj index
    always_ff @(posedge clk)
    begin
        pa_reg[0] <= mul_el(m[4], m[8]);  pb_reg[0] <= mul_el(m[5], m[7]);
        pa_reg[1] <= mul_el(m[2], m[7]);  pb_reg[1] <= mul_el(m[1], m[8]);
        pa_reg[2] <= mul_el(m[1], m[5]);  pb_reg[2] <= mul_el(m[2], m[4]);
        pa_reg[3] <= mul_el(m[5], m[6]);  pb_reg[3] <= mul_el(m[3], m[8]);
        pa_reg[4] <= mul_el(m[0], m[8]);  pb_reg[4] <= mul_el(m[2], m[6]);
        pa_reg[5] <= mul_el(m[2], m[3]);  pb_reg[5] <= mul_el(m[0], m[5]);
        pa_reg[6] <= mul_el(m[3], m[7]);  pb_reg[6] <= mul_el(m[4], m[6]);
        pa_reg[7] <= mul_el(m[1], m[6]);  pb_reg[7] <= mul_el(m[0], m[7]);
        pa_reg[8] <= mul_el(m[0], m[4]);  pb_reg[8] <= mul_el(m[1], m[3]);
        for (int i = 0; i < 3; i++)
        begin
            mr1_reg[i] <= m[i];
            tt1_reg[i] <= t[i];
        end
    end

    // Stage 2: cofactors, exact in 65 bits
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            adj_reg[k] <= ADJ_W'(pa_reg[k]) - ADJ_W'(pb_reg[k]);
        mr2_reg <= mr1_reg;
        tt2_reg <= tt1_reg;
    end

    // Stage 3: split each 32 x 65 product into a low and a high half.
    // Terms 0..2 feed the determinant, term 3+3c+i is t[i] * adj[i][c].
    for (genvar k = 0; k < NPROD; k++)
    begin : g_part
        localparam int C   = (k < 3) ? 0 : (k - 3) / 3;
        localparam int I   = (k < 3) ? k : (k - 3) % 3;
        localparam int AIX = (k < 3) ? k * 3 : I * 3 + C;
        logic signed [IN_W-1:0]  a;
        logic signed [ADJ_W-1:0] cf;
        assign a  = (k < 3) ? mr2_reg[I] : tt2_reg[I];
        assign cf = adj_reg[AIX];

        always_ff @(posedge clk)
        begin
            lo_reg[k] <= PART_W'(a) * PART_W'($signed({1'b0, cf[IN_W-1:0]}));
            hi_reg[k] <= PART_W'(a) * PART_W'($signed(cf[ADJ_W-1:IN_W]));
        end

        assign prod[k] = (SUM_W'(hi_reg[k]) <<< IN_W) + SUM_W'(lo_reg[k]);
    end

    // Stage 4: determinant and the three numerators
    always_ff @(posedge clk)
    begin
        det_reg <= prod[0] + prod[1] + prod[2];
        for (int c = 0; c < 3; c++)
            num_reg[c] <= prod[3 + 3 * c] + prod[4 + 3 * c] + prod[5 + 3 * c];
    end

    // Stage 5: scale, take magnitudes, bias by half the divisor for rounding
    always_ff @(posedge clk)
    begin : s5
        logic [WIDE_W-1:0] n;
        logic [WIDE_W-1:0] an;
        logic [SUM_W-1:0]  ad;
        ad = det_reg[SUM_W-1] ? SUM_W'(-det_reg) : SUM_W'(det_reg);
        for (int c = 0; c < 3; c++)
        begin
            n  = WIDE_W'(num_reg[c]) << FRAC_BITS;
            an = n[WIDE_W-1] ? (~n + WIDE_W'(1)) : n;
            np_reg[c]  <= (an << 1) + WIDE_W'(ad);
            neg_reg[c] <= (n[WIDE_W-1] == det_reg[SUM_W-1]);
        end
        dp_reg    <= {ad, 1'b0};
        sing5_reg <= (det_reg == '0);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] mag;

        epvm_div #(
            .TAG_W (2)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v5_reg),
            .num       (np_reg[c]),
            .den       (dp_reg),
            .tag       ({sing5_reg, neg_reg[c]}),
            .out_valid (dv[c]),
            .quo       (dq[c]),
            .ovf       (dovf[c]),
            .out_tag   (dtag[c])
        );

        // saturate to the Q32.16 range, then apply the sign; a singular matrix gives zero
        assign lim = dtag[c][0] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        assign mag = (dovf[c] || dq[c] > lim) ? lim : dq[c];
        assign res[c] = dtag[c][1] ? '0
                      : (dtag[c][0] ? $signed(-mag) : $signed(mag));
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            eye_reg[c] <= res[c];
        sing_reg <= dtag[0][1];
    end

    assign done     = done_reg;
    assign eye_x    = eye_reg[0];
    assign eye_y    = eye_reg[1];
    assign eye_z    = eye_reg[2];
    assign singular = sing_reg;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eye position pipeline: drives random and
// corner-case matrices, predicts each eye position and flag exactly, and
// compares every done strobe with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

// Holds predicted eye positions in order and counts mismatches.
class eye_scoreboard;
    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
        logic               sing;
    } eye_t;

    eye_t pending[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    // Round half away from zero and saturate one component.
    function logic signed [47:0] solve_axis(logic signed [127:0] num,
                                            logic signed [127:0] det);
        logic signed [127:0] n;
        logic [127:0]        an;
        logic [127:0]        ad;
        logic [127:0]        q;
        logic                neg;
        logic [127:0]        lim;
        n   = num <<< 16;
        neg = !(n[127] != det[127]);
        an  = n[127] ? -n : n;
        ad  = det[127] ? -det : det;
        q   = ((an << 1) + ad) / (ad << 1);
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? -q[47:0] : q[47:0];
    endfunction

    // Note one accepted matrix: compute adjugate, determinant and position.
    function void note_matrix(logic signed [31:0] m[9], logic signed [31:0] t[3]);
        logic signed [127:0] a[9];
        logic signed [127:0] mm[9];
        logic signed [127:0] tt[3];
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic signed [47:0]  e[3];
        eye_t                r;
        foreach (mm[i]) mm[i] = m[i];
        foreach (tt[i]) tt[i] = t[i];
        a[0] = mm[4]*mm[8] - mm[5]*mm[7];
        a[1] = mm[2]*mm[7] - mm[1]*mm[8];
        a[2] = mm[1]*mm[5] - mm[2]*mm[4];
        a[3] = mm[5]*mm[6] - mm[3]*mm[8];
        a[4] = mm[0]*mm[8] - mm[2]*mm[6];
        a[5] = mm[2]*mm[3] - mm[0]*mm[5];
        a[6] = mm[3]*mm[7] - mm[4]*mm[6];
        a[7] = mm[1]*mm[6] - mm[0]*mm[7];
        a[8] = mm[0]*mm[4] - mm[1]*mm[3];
        det = mm[0]*a[0] + mm[1]*a[3] + mm[2]*a[6];
        if (det == 0)
        begin
            r = '{48'sd0, 48'sd0, 48'sd0, 1'b1};
        end
        else
        begin
            for (int j = 0; j < 3; j++)
            begin
                num  = tt[0]*a[j] + tt[1]*a[3+j] + tt[2]*a[6+j];
                e[j] = solve_axis(num, det);
            end
            r = '{e[0], e[1], e[2], 1'b0};
        end
        pending.push_back(r);
    endfunction

    function void report(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endfunction

    // Check one result strobe against the oldest prediction.
    function void check_result(logic [47:0] x, logic [47:0] y, logic [47:0] z,
                               logic s);
        eye_t w;
        if (pending.size() == 0)
        begin
            report("unexpected result", x, 0);
            return;
        end
        w = pending.pop_front();
        if (x !== w.x) report("eye_x", x, w.x);
        if (y !== w.y) report("eye_y", y, w.y);
        if (z !== w.z) report("eye_z", z, w.z);
        if (s !== w.sing) report("singular", s, w.sing);
    endfunction
endclass

module tb_top;
    import epvm_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [IN_W-1:0] rot[9];
    logic signed [IN_W-1:0] trans[3];
    logic done;
    logic signed [OUT_W-1:0] eye_x;
    logic signed [OUT_W-1:0] eye_y;
    logic signed [OUT_W-1:0] eye_z;
    logic singular;

    eye_scoreboard board;

    eye_position_from_view_matrix uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .rot_00(rot[0]), .rot_01(rot[1]), .rot_02(rot[2]),
        .rot_10(rot[3]), .rot_11(rot[4]), .rot_12(rot[5]),
        .rot_20(rot[6]), .rot_21(rot[7]), .rot_22(rot[8]),
        .trans_x(trans[0]), .trans_y(trans[1]), .trans_z(trans[2]),
        .done(done), .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .singular(singular)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Note accepted matrices and check results, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_matrix(rot, trans);
        if (rst_n && done)
            board.check_result(eye_x, eye_y, eye_z, singular);
    end

    // Pick a field value: extremes often, small Q16.16 values, or anything.
    function logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            5, 6: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // Present one matrix; hold start high across a burst and drop it after.
    task automatic send_matrix(logic [31:0] m[9], logic [31:0] t[3], bit keep);
        foreach (m[i]) rot[i] = m[i];
        foreach (t[i]) trans[i] = t[i];
        start = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (!keep)
            start = 1'b0;
    endtask

    task automatic send_random(bit keep);
        logic [31:0] m[9];
        logic [31:0] t[3];
        int kind;
        kind = $urandom_range(0, 9);
        foreach (m[i]) m[i] = pick_field();
        foreach (t[i]) t[i] = pick_field();
        // Steer some matrices singular: copy a row or zero a column.
        if (kind == 0)
            for (int c = 0; c < 3; c++) m[6+c] = m[c];
        else if (kind == 1)
            for (int r = 0; r < 3; r++) m[3*r+1] = 0;
        send_matrix(m, t, keep);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] m[9];
        logic [31:0] t[3];
        int left;
        int burst;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        foreach (rot[i]) rot[i] = '0;
        foreach (trans[i]) trans[i] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: identity, scaled identity, zero and full-scale cases.
        m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        t = '{32'h10000, 32'hFFFE_0000, 32'h3_0000};
        send_matrix(m, t, 0);
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        send_matrix(m, t, 0);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1};     // saturates eye_y at the positive limit
        send_matrix(m, t, 1);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};               // zero determinant
        send_matrix(m, t, 1);
        m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF};
        send_matrix(m, t, 1);
        foreach (m[i]) m[i] = 32'hFFFF_FFFF;             // singular, all ones
        t = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_matrix(m, t, 1);
        m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};               // rounding of thirds
        t = '{1, 2, 32'hFFFF_FFFF};
        send_matrix(m, t, 1);
        m = '{2, 0, 0, 0, 2, 0, 0, 0, 2};
        t = '{32'hFFFF_FFFF, 3, 32'h8000_0000};
        send_matrix(m, t, 0);
        for (int i = 0; i < 16; i++)
            send_random(0);

        // Hold off until the pipeline has emptied.
        drain();

        // Random bursts with random gaps, some long stretches without gaps.
        left = 400;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
                send_random(i != burst - 1);
            left -= burst;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end

        drain();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
